// ===== rtl/hlrp_pkg.sv =====
// Package for the HIGHLOW relocation patcher: field widths, register indexes
// and the result bundle passed from the byte ALU to the top level.
// No dependencies.
package hlrp_pkg;

   localparam int DATA_W          = 8;
   localparam int WORD_W          = 32;
   localparam int CSR_IDX_W       = 2;
   localparam int BASE_ALIGN_BITS = 16;   // 64 KiB alignment of the link base

   localparam logic [CSR_IDX_W-1:0] CSR_WORD_START_MASK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_BASE       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_BASE       = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] out_byte;
      logic              setup_ok;
      logic              next_carry;
   } alu_res_type;

endpackage

// ===== rtl/hlrp_byte_alu.sv =====
// Byte ALU of the relocation patcher: set-up check, word/byte lane select and
// the carry-chained 8-bit add of one delta byte. Depends on hlrp_pkg.
module hlrp_byte_alu #(
   parameter int PREFIX_BYTES = 20
) (
   input  logic [$clog2(PREFIX_BYTES)-1:0]  pos,
   input  logic                             carry,
   input  logic [hlrp_pkg::DATA_W-1:0]      data_byte,
   input  logic [hlrp_pkg::WORD_W-1:0]      word_start_mask,
   input  logic [hlrp_pkg::WORD_W-1:0]      link_base,
   input  logic [hlrp_pkg::WORD_W-1:0]      load_base,
   output hlrp_pkg::alu_res_type            res
);
   import hlrp_pkg::*;

   // word starts may sit at offsets 0 .. PREFIX_BYTES-4
   localparam logic [WORD_W-1:0] ALLOWED_MASK =
      WORD_W'((64'd1 << (PREFIX_BYTES - 3)) - 64'd1);

   logic [WORD_W-1:0] diff;
   logic              bad_high;
   logic              bad_base;
   logic              overlap;
   logic              ok;

   always_comb begin
      diff     = load_base - link_base;
      bad_high = |(word_start_mask & ~ALLOWED_MASK);
      bad_base = (word_start_mask != '0) &&
                 ((link_base == '0) || (link_base[BASE_ALIGN_BITS-1:0] != '0));
      overlap  = |(word_start_mask & ((word_start_mask >> 1) | (word_start_mask >> 2) |
                                      (word_start_mask >> 3)));
      ok       = !(bad_high || bad_base || overlap);
   end

   always_comb begin
      logic              found;
      logic [5:0]        pos_ext;
      logic [5:0]        idx;
      logic [DATA_W:0]   sum;
      logic              cin;
      found          = 1'b0;
      pos_ext        = 6'(pos);
      idx            = '0;
      sum            = '0;
      cin            = 1'b0;
      res.out_byte   = data_byte;
      res.setup_ok   = ok;
      res.next_carry = 1'b0;
      if (ok) begin
         // k = byte lane within the word; lowest lane wins
         for (int k = 0; k < 4; k++) begin
            idx = pos_ext - 6'(k);
            if (!found && (pos_ext >= 6'(k)) && word_start_mask[idx[4:0]]) begin
               found          = 1'b1;
               cin            = (k == 0) ? 1'b0 : carry;
               sum            = {1'b0, data_byte} + {1'b0, diff[8*k +: DATA_W]} +
                                (DATA_W+1)'(cin);
               res.out_byte   = sum[DATA_W-1:0];
               res.next_carry = sum[DATA_W];
            end
         end
      end
   end

endmodule

// ===== rtl/highlow_relocation_patcher_top.sv =====
// Top level of the HIGHLOW relocation patcher: CSR bank, prefix position and
// carry state, result register. Depends on hlrp_pkg and hlrp_byte_alu.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_data_byte
//   rsp     | out       | rsp_valid / rsp_ready | rsp_out_byte, rsp_setup_ok, rsp_prefix_end
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// One byte per cycle unless rsp stalls; a result appears in the cycle after its request.
// The single result register sets latency; req_ready stays high while the
// result is being taken, so transfers run back to back.
// A stalled rsp holds the register and drops req_ready. csr_ready is always high.
// Synchronous reset clears the CSRs, position, carry and rsp_valid.
module highlow_relocation_patcher_top #(
   parameter int PREFIX_BYTES = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [hlrp_pkg::DATA_W-1:0]      req_data_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [hlrp_pkg::DATA_W-1:0]      rsp_out_byte,
   output logic                             rsp_setup_ok,
   output logic                             rsp_prefix_end,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hlrp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hlrp_pkg::WORD_W-1:0]      csr_data
);
   import hlrp_pkg::*;

   localparam int POS_W = $clog2(PREFIX_BYTES);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(PREFIX_BYTES - 1);

   logic [WORD_W-1:0] mask_ff, mask_in;
   logic [WORD_W-1:0] pref_ff, pref_in;
   logic [WORD_W-1:0] act_ff,  act_in;
   logic [POS_W-1:0]  pos_ff,  pos_in;
   logic              carry_ff, carry_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] out_byte_ff, out_byte_in;
   logic              setup_ok_ff, setup_ok_in;
   logic              prefix_end_ff, prefix_end_in;

   logic              req_xfer;
   logic              at_end;
   alu_res_type       alu_res;

   hlrp_byte_alu #(
      .PREFIX_BYTES (PREFIX_BYTES)
   ) u_alu (
      .pos             (pos_ff),
      .carry           (carry_ff),
      .data_byte       (req_data_byte),
      .word_start_mask (mask_ff),
      .link_base       (pref_ff),
      .load_base       (act_ff),
      .res             (alu_res)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign at_end    = (pos_ff == LAST_POS);
   assign csr_ready = 1'b1;

   always_comb begin
      mask_in = mask_ff;
      pref_in = pref_ff;
      act_in  = act_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WORD_START_MASK: mask_in = csr_data;
            CSR_LINK_BASE:       pref_in = csr_data;
            CSR_LOAD_BASE:       act_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_in        = pos_ff;
      carry_in      = carry_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      out_byte_in   = out_byte_ff;
      setup_ok_in   = setup_ok_ff;
      prefix_end_in = prefix_end_ff;
      if (req_xfer) begin
         pos_in        = at_end ? '0 : pos_ff + 1'b1;
         carry_in      = alu_res.next_carry;
         rsp_valid_in  = 1'b1;
         out_byte_in   = alu_res.out_byte;
         setup_ok_in   = alu_res.setup_ok;
         prefix_end_in = at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         pref_ff      <= '0;
         act_ff       <= '0;
         pos_ff       <= '0;
         carry_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         pref_ff      <= pref_in;
         act_ff       <= act_in;
         pos_ff       <= pos_in;
         carry_ff     <= carry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff   <= out_byte_in;
      setup_ok_ff   <= setup_ok_in;
      prefix_end_ff <= prefix_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_setup_ok   = setup_ok_ff;
   assign rsp_prefix_end = prefix_end_ff;

endmodule

// ===== rtl/hlrp_checker.sv =====
// Port-level checks for the relocation patcher, bound to the top level.
// Depends on hlrp_pkg and highlow_relocation_patcher_top.
module hlrp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [hlrp_pkg::DATA_W-1:0] req_data_byte,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [hlrp_pkg::DATA_W-1:0] rsp_out_byte,
   input logic                        rsp_setup_ok
);
   import hlrp_pkg::*;

   // result register empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // an empty result register never blocks a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with no pending result");

   // every request transfer yields a result next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("request transfer without result");

   // invalid set-up passes the byte through untouched
   a_passthrough: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=>
         (rsp_setup_ok || (rsp_out_byte == $past(req_data_byte))))
      else $error("byte altered with invalid set-up");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_byte)))
      else $error("stalled result changed");

endmodule

bind highlow_relocation_patcher_top hlrp_checker u_hlrp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_data_byte (req_data_byte),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_setup_ok  (rsp_setup_ok)
);

// ===== bench/testbench.sv =====
// Self-checking bench for highlow_relocation_patcher_top: directed table, then random config
// phases with byte streams, checked against table results or an in-bench relocation predictor.
// Depends on hlrp_pkg and the patcher RTL.
`timescale 1ns / 1ps

module testbench;
   import hlrp_pkg::*;

   localparam int PREFIX_BYTES = 20;
   localparam int RANDOM_BYTES = 400;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;   // unmapped index, writes are dropped

   typedef struct packed {
      logic [DATA_W-1:0] out_byte;
      logic              setup_ok;
      logic              prefix_end;
   } patch_result_type;

   typedef enum bit {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [WORD_W-1:0]    value;
      logic [DATA_W-1:0]    data;
      bit                   typed;
      patch_result_type     exp;
   } dir_row_type;

   logic                 clock;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic [DATA_W-1:0]    req_data_byte  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic [DATA_W-1:0]    rsp_out_byte;
   logic                 rsp_setup_ok;
   logic                 rsp_prefix_end;
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   logic [WORD_W-1:0]    csr_data       = '0;

   // predictor state
   logic [WORD_W-1:0]    reloc_mask = '0;
   logic [WORD_W-1:0]    pref_base  = '0;
   logic [WORD_W-1:0]    act_base   = '0;
   logic [4:0]           byte_pos   = '0;
   logic                 carry_q    = 1'b0;

   patch_result_type     pending_patches [$];
   int                   error_count = 0;
   int                   bytes_sent  = 0;
   int                   stall_left  = 0;
   bit                   idle_on     = 1'b1;

   dir_row_type directed_rows [0:30] = '{
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'hff, 1'b1, '{8'hff, 1'b1, 1'b0}},
      '{ROW_CSR,  CSR_WORD_START_MASK, 32'h0002_0000, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_CSR,  CSR_LINK_BASE,       32'h0001_0000, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'ha5, 1'b1, '{8'ha5, 1'b0, 1'b0}},
      '{ROW_CSR,  CSR_WORD_START_MASK, 32'h0000_0001, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_CSR,  CSR_LINK_BASE,       32'h0001_8000, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'h5a, 1'b1, '{8'h5a, 1'b0, 1'b0}},
      '{ROW_CSR,  CSR_LINK_BASE,       32'h0000_0000, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'h3c, 1'b1, '{8'h3c, 1'b0, 1'b0}},
      '{ROW_CSR,  CSR_LINK_BASE,       32'h0001_0000, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_CSR,  CSR_WORD_START_MASK, 32'h0000_0003, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'hc3, 1'b1, '{8'hc3, 1'b0, 1'b0}},
      // words at bytes 6 and 16, delta of one: full carry ripple through 0xff bytes
      '{ROW_CSR,  CSR_WORD_START_MASK, 32'h0001_0040, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_CSR,  CSR_LOAD_BASE,       32'h0001_0001, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'hff, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'hff, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'hff, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'hff, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'h01, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'h80, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'h7f, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'hfe, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'h10, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'hef, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'hff, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'hff, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'hff, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'hff, 1'b1, '{8'h00, 1'b1, 1'b1}},
      '{ROW_CSR,  CSR_SPARE,           32'hffff_ffff, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, CSR_WORD_START_MASK, 32'h0, 8'h42, 1'b1, '{8'h42, 1'b1, 1'b0}}
   };

   highlow_relocation_patcher_top #(.PREFIX_BYTES(PREFIX_BYTES)) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_setup_ok   (rsp_setup_ok),
      .rsp_prefix_end (rsp_prefix_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // Relocated byte for the next prefix position; advances position and carry.
   function automatic patch_result_type predict_patch(input logic [DATA_W-1:0] data);
      patch_result_type res;
      logic [WORD_W-1:0] allowed;
      logic [WORD_W-1:0] delta;
      logic [8:0]        sum;
      logic              ok;
      logic              hit;
      logic              next_carry;
      allowed = (32'd1 << (PREFIX_BYTES - 3)) - 32'd1;
      ok = 1'b1;
      if ((reloc_mask & ~allowed) != 0)
         ok = 1'b0;
      if (reloc_mask != 0 && (pref_base == 0 || pref_base[BASE_ALIGN_BITS-1:0] != 0))
         ok = 1'b0;
      if ((reloc_mask & ((reloc_mask >> 1) | (reloc_mask >> 2) | (reloc_mask >> 3))) != 0)
         ok = 1'b0;
      delta = act_base - pref_base;
      res.out_byte = data;
      hit = 1'b0;
      next_carry = 1'b0;
      if (ok) begin
         for (int k = 0; k < 4; k++) begin
            if (!hit && byte_pos >= k && reloc_mask[byte_pos - k]) begin
               hit = 1'b1;
               sum = {1'b0, data} + {1'b0, delta[8*k +: 8]} +
                     ((k == 0) ? 9'd0 : {8'd0, carry_q});
               res.out_byte = sum[7:0];
               next_carry = sum[8];
            end
         end
      end
      res.setup_ok = ok;
      res.prefix_end = (byte_pos == PREFIX_BYTES - 1);
      carry_q = next_carry;
      byte_pos = res.prefix_end ? 5'd0 : byte_pos + 5'd1;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic wait_idle();
      while (pending_patches.size() != 0)
         @(posedge clock);
   endtask

   // csr_valid is left high on return; the next send_byte call drops it
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      case (idx)
         CSR_WORD_START_MASK: reloc_mask = value;
         CSR_LINK_BASE:       pref_base  = value;
         CSR_LOAD_BASE:       act_base   = value;
         default: ;
      endcase
   endtask

   task automatic send_byte(input logic [DATA_W-1:0] data, input bit typed,
                            input patch_result_type typed_res);
      patch_result_type pred;
      csr_valid     <= 1'b0;
      req_valid     <= 1'b1;
      req_data_byte <= data;
      do
         @(posedge clock);
      while (!req_ready);
      pred = predict_patch(data);
      pending_patches.push_back(typed ? typed_res : pred);
      bytes_sent++;
   endtask

   task automatic configure_phase();
      logic [WORD_W-1:0] m;
      logic [WORD_W-1:0] pb;
      logic [WORD_W-1:0] ab;
      int mode;
      int k;
      mode = $urandom_range(0, 9);
      m = '0;
      k = 0;
      while (k <= PREFIX_BYTES - 4) begin
         if ($urandom_range(0, 2) == 0) begin
            m[k] = 1'b1;
            k += 4;
         end else
            k += 1;
      end
      pb = ($urandom_range(0, 5) == 0) ? 32'hffff_0000 : {16'($urandom_range(1, 65535)), 16'h0};
      case ($urandom_range(0, 5))
         0:       ab = 32'h0;
         1:       ab = 32'hffff_ffff;
         2:       ab = pb;
         3:       ab = pb + $urandom_range(0, 255);
         default: ab = $urandom();
      endcase
      if (mode == 7)
         m = $urandom();
      else if (mode == 8)
         pb = $urandom();
      else if (mode == 9)
         pb = '0;
      // sometimes keep the previous set-up so a stream runs on unchanged
      if ($urandom_range(0, 4) != 0) write_csr(CSR_WORD_START_MASK, m);
      if ($urandom_range(0, 4) != 0) write_csr(CSR_LINK_BASE, pb);
      if ($urandom_range(0, 4) != 0) write_csr(CSR_LOAD_BASE, ab);
      if (mode == 9) write_csr(CSR_SPARE, $urandom());
   endtask

   // result sink with random stall bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      patch_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_patches.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_out_byte, 8'h00);
         end else begin
            want = pending_patches.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report_mismatch("out_byte", rsp_out_byte, want.out_byte);
            if (rsp_setup_ok !== want.setup_ok)
               report_mismatch("setup_ok", 8'(rsp_setup_ok), 8'(want.setup_ok));
            if (rsp_prefix_end !== want.prefix_end)
               report_mismatch("prefix_end", 8'(rsp_prefix_end), 8'(want.prefix_end));
         end
      end
   end

   initial begin
      int n;
      int gap;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            req_valid <= 1'b0;
            wait_idle();
            write_csr(directed_rows[r].idx, directed_rows[r].value);
         end else begin
            send_byte(directed_rows[r].data, directed_rows[r].typed, directed_rows[r].exp);
         end
      end

      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         req_valid <= 1'b0;
         wait_idle();
         configure_phase();
         n = $urandom_range(10, 40);
         repeat (n) begin
            // bias toward 0xff so carries ripple across whole words
            send_byte(($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom_range(0, 255)),
                      1'b0, '0);
            if (bytes_sent >= RANDOM_BYTES - 80)
               idle_on <= 1'b0;
            if (idle_on && $urandom_range(0, 5) == 0) begin
               gap = $urandom_range(1, 3);
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end

      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      wait_idle();
      repeat (4) @(posedge clock);
      if (error_count == 0 && pending_patches.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
